// ----- rtl/core/lsra_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsra_pkg: shared definitions for the linear scan register allocator
// Parameter defaults, status codes and the broadcast control struct used by
// the register cells.
// ----------------------------------------------------------------------------
package lsra_pkg;

    // Parameter defaults
    localparam int NUM_REGISTERS_DEF = 32;
    localparam int INDEX_BITS_DEF    = 16;

    // Fixed field widths
    localparam int MASK_W    = 32;
    localparam int REG_NUM_W = 5;
    localparam int STATUS_W  = 2;

    // Reserved mask after reset: zero, return address, stack, global pointer
    localparam logic [MASK_W-1:0] RESERVED_RESET = 32'h0000_000F;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PREASSIGNED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SPILL       = 2'd2;

    // Control broadcast to every cell for one transaction
    typedef struct packed {
        logic take;      // transaction accepted this cycle
        logic restart;   // first interval of a block
        logic alloc_en;  // interval wants a register
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/linear_scan_register_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linear_scan_register_allocator: linear scan allocation, one interval a cycle
// Row of register cells with a lowest-free carry chain and a result register.
// ----------------------------------------------------------------------------
// Usage: busy stays low, so a transaction is taken on every cycle that start
// is high. Each accepted interval yields exactly one result, shown with done
// high for one cycle on the cycle after acceptance; the receiver cannot stall
// it. The rate of one interval per cycle is set by one pass through the row of
// NUM_REGISTERS cells: all cells compare their stored end with the new start
// in parallel, then a carry chain across the row picks the lowest free
// register. A write to reserved_mask takes effect at the next first_of_block
// interval or at reset.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator #(
    parameter int NUM_REGISTERS = lsra_pkg::NUM_REGISTERS_DEF,
    parameter int INDEX_BITS    = lsra_pkg::INDEX_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [INDEX_BITS-1:0]             start_index,
    input  wire  [INDEX_BITS-1:0]             end_index,
    input  wire                               preassigned,
    input  wire                               first_of_block,
    input  wire                               reserved_mask_we,
    input  wire  [lsra_pkg::MASK_W-1:0]       reserved_mask_wdata,
    output logic                              done,
    output logic [lsra_pkg::STATUS_W-1:0]     status,
    output logic [lsra_pkg::REG_NUM_W-1:0]    register_number
);

    localparam int IDX_W = $clog2(NUM_REGISTERS);

    // Busy bits after reset, one per register; bits past the mask width are clear
    localparam logic [NUM_REGISTERS-1:0] RESET_BUSY_VEC =
        NUM_REGISTERS'(lsra_pkg::RESERVED_RESET);

    logic [lsra_pkg::MASK_W-1:0]    reserved_mask_reg;
    logic                           done_reg;
    logic [lsra_pkg::STATUS_W-1:0]  status_reg;
    logic [lsra_pkg::STATUS_W-1:0]  status_next;
    logic [lsra_pkg::REG_NUM_W-1:0] regnum_reg;
    logic [lsra_pkg::REG_NUM_W-1:0] regnum_next;

    lsra_pkg::cell_ctrl_t     ctrl;
    logic [NUM_REGISTERS:0]   carry;
    logic [NUM_REGISTERS-1:0] grant_vec;
    logic [NUM_REGISTERS-1:0] busy_vec;
    logic [NUM_REGISTERS-1:0] reserved_vec;
    logic [IDX_W-1:0]         grant_idx;
    logic [31:0]              grant_idx_wide;

    // One transaction per cycle
    assign busy = 1'b0;

    // Broadcast control
    always_comb
    begin
        ctrl.take     = start;
        ctrl.restart  = first_of_block;
        ctrl.alloc_en = ~preassigned;
    end

    // Reserved bits beyond the mask width read as zero
    genvar g;
    generate
        for (g = 0; g < NUM_REGISTERS; g++)
        begin : g_res
            if (g < lsra_pkg::MASK_W)
            begin : g_in
                assign reserved_vec[g] = reserved_mask_reg[g];
            end
            else
            begin : g_out
                assign reserved_vec[g] = 1'b0;
            end
        end
    endgenerate

    // Row of register cells, chained by the lowest-free carry
    assign carry[0] = 1'b0;
    generate
        for (g = 0; g < NUM_REGISTERS; g++)
        begin : g_cell
            lsra_cell #(
                .INDEX_BITS (INDEX_BITS),
                .IS_ZERO    (g == 0),
                .RESET_BUSY (RESET_BUSY_VEC[g])
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .start_index  (start_index),
                .end_index    (end_index),
                .reserved_bit (reserved_vec[g]),
                .carry_in     (carry[g]),
                .carry_out    (carry[g+1]),
                .grant        (grant_vec[g]),
                .busy_q       (busy_vec[g])
            );
        end
    endgenerate

    // Encode the one-hot grant and select the status
    always_comb
    begin
        grant_idx = '0;
        for (int r = 0; r < NUM_REGISTERS; r++)
        begin
            if (grant_vec[r])
            begin
                grant_idx = grant_idx | IDX_W'(r);
            end
        end
        grant_idx_wide = 32'(grant_idx);
        if (preassigned)
        begin
            status_next = lsra_pkg::ST_PREASSIGNED;
            regnum_next = '0;
        end
        else if (!carry[NUM_REGISTERS])
        begin
            status_next = lsra_pkg::ST_SPILL;
            regnum_next = '0;
        end
        else
        begin
            status_next = lsra_pkg::ST_ALLOCATED;
            regnum_next = grant_idx_wide[lsra_pkg::REG_NUM_W-1:0];
        end
    end

    // Hold the reserved mask and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_mask_reg <= lsra_pkg::RESERVED_RESET;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (reserved_mask_we)
            begin
                reserved_mask_reg <= reserved_mask_wdata;
            end
            done_reg <= start;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg <= status_next;
            regnum_reg <= regnum_next;
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign register_number = regnum_reg;

    // At most one cell claims the interval
    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_vec))
        else $error("more than one cell granted");

    // Every accepted transaction yields one result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result without accepted transaction");

    // A spill leaves every register busy
    a_spill_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == lsra_pkg::ST_SPILL) |-> (&busy_vec))
        else $error("spill reported with a free register");

    // Register number is zero unless allocated
    a_regnum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != lsra_pkg::ST_ALLOCATED) |-> (register_number == '0))
        else $error("register number set without allocation");

endmodule
`default_nettype wire

// ----- rtl/core/lsra_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsra_cell: one register slot of the allocator
// Holds the busy bit of its register and the end of the active interval that
// uses it. Expires that interval against the broadcast start, and takes the
// new interval when free and no lower cell has claimed it (carry chain).
// ----------------------------------------------------------------------------
module lsra_cell #(
    parameter int INDEX_BITS = lsra_pkg::INDEX_BITS_DEF,
    parameter bit IS_ZERO    = 1'b0,
    parameter bit RESET_BUSY = 1'b0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  lsra_pkg::cell_ctrl_t     ctrl,
    input  wire  [INDEX_BITS-1:0]    start_index,
    input  wire  [INDEX_BITS-1:0]    end_index,
    input  wire                      reserved_bit,
    input  wire                      carry_in,
    output logic                     carry_out,
    output logic                     grant,
    output logic                     busy_q
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [INDEX_BITS-1:0] end_reg;

    logic base_busy;
    logic base_valid;
    logic expire;
    logic busy_now;

    // Restart, expire, then claim if free and not already taken below
    always_comb
    begin
        base_busy  = ctrl.restart ? reserved_bit : busy_reg;
        base_valid = ctrl.restart ? 1'b0 : valid_reg;
        expire     = base_valid && (end_reg <= start_index);
        // register zero keeps its busy bit on expiry
        busy_now   = base_busy & ~(expire & ~IS_ZERO);
        grant      = ctrl.alloc_en & ~busy_now & ~carry_in;
        carry_out  = carry_in | ~busy_now;
        busy_next  = ctrl.take ? (busy_now | grant) : busy_reg;
        valid_next = ctrl.take ? ((base_valid & ~expire) | grant) : valid_reg;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= RESET_BUSY;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // Capture the end of the interval that takes this register
    always_ff @(posedge clk)
    begin
        if (ctrl.take && grant)
        begin
            end_reg <= end_index;
        end
    end

    assign busy_q = busy_reg;

endmodule
`default_nettype wire
